// File: design/dcgp_pkg.sv
// shared types, constants and codes for the dmx channel group packetizer
package dcgp_pkg;

  localparam int GROUP_SIZE_DEF  = 16;
  localparam int MAX_CHANNEL_DEF = 512;

  localparam int CODE_W  = 8;
  localparam int CH_W    = 10;
  localparam int LEVEL_W = 8;
  localparam int PID_W   = 8;
  localparam int SIZE_W  = 5;
  localparam int TDATA_W = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [PID_W-1:0] GROUP_ID_BASE_RST = 8'h20;
  localparam logic [PID_W-1:0] COMMIT_ID_RST     = 8'h40;

  // register index, taken from paddr[2]
  localparam logic REG_GROUP_ID_BASE = 1'b0;
  localparam logic REG_COMMIT_ID     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROC,
    ST_EMIT_OLD,
    ST_FLUSH,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic store;
    logic emit_group;
    logic emit_commit;
    logic run_last;
    logic close_group;
    logic clear_frame;
  } cmd_t;

  typedef struct packed {
    logic valid_store;
    logic change;
    logic flush_needed;
    logic dropping;
    logic eof;
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage

// File: design/dcgp_cfg.sv
// apb register block: group id base and commit id
module dcgp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcgp_pkg::APB_AW-1:0] paddr,
  input  logic [dcgp_pkg::APB_DW-1:0] pwdata,
  output logic [dcgp_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [dcgp_pkg::PID_W-1:0]  group_id_base,
  output logic [dcgp_pkg::PID_W-1:0]  commit_id
);
  import dcgp_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_id_base <= GROUP_ID_BASE_RST;
      commit_id     <= COMMIT_ID_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GROUP_ID_BASE: group_id_base <= pwdata[PID_W-1:0];
        REG_COMMIT_ID:     commit_id     <= pwdata[PID_W-1:0];
        default:           group_id_base <= group_id_base;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GROUP_ID_BASE: prdata = APB_DW'(group_id_base);
      REG_COMMIT_ID:     prdata = APB_DW'(commit_id);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: design/dcgp_ctrl.sv
// controller: sequences accept, store, group bursts and the commit beat
module dcgp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  dcgp_pkg::sts_t sts,
  output dcgp_pkg::cmd_t cmd
);
  import dcgp_pkg::*;

  state_t state;
  state_t state_next;
  logic   split;

  assign split = sts.valid_store & sts.change;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_PROC;
      end
      ST_PROC: begin
        if (split) begin
          state_next = ST_EMIT_OLD;
        end else if (sts.eof) begin
          if (sts.dropping)          state_next = ST_IDLE;
          else if (sts.flush_needed) state_next = ST_FLUSH;
          else                       state_next = ST_COMMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_OLD: begin
        if (sts.out_free && sts.last_byte) state_next = ST_PROC;
      end
      ST_FLUSH: begin
        if (sts.out_free && sts.last_byte) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_PROC: begin
        if (!split) begin
          cmd.store       = sts.valid_store;
          cmd.clear_frame = sts.eof & sts.dropping;
        end
      end
      ST_EMIT_OLD: begin
        cmd.emit_group  = sts.out_free;
        cmd.run_last    = ~sts.eof & sts.last_byte;
        cmd.close_group = sts.out_free & sts.last_byte;
      end
      ST_FLUSH: begin
        cmd.emit_group = sts.out_free;
      end
      ST_COMMIT: begin
        cmd.emit_commit = sts.out_free;
        cmd.run_last    = 1'b1;
        cmd.clear_frame = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/dcgp_dp.sv
// datapath: item registers, level buffer, frame state and output register
module dcgp_dp #(
  parameter int GROUP_SIZE  = dcgp_pkg::GROUP_SIZE_DEF,
  parameter int MAX_CHANNEL = dcgp_pkg::MAX_CHANNEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dcgp_pkg::TDATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dcgp_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser,
  input  logic [dcgp_pkg::PID_W-1:0]   group_id_base,
  input  logic [dcgp_pkg::PID_W-1:0]   commit_id,
  input  dcgp_pkg::cmd_t               cmd,
  output dcgp_pkg::sts_t               sts
);
  import dcgp_pkg::*;

  localparam int FILL_W   = $clog2(GROUP_SIZE + 1);
  localparam int IDX_W    = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam int NUM_GRP  = (MAX_CHANNEL - 1) / GROUP_SIZE + 1;
  localparam int GRP_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int RS       = CH_W + $clog2(GROUP_SIZE);
  localparam int RECIP    = (2 ** RS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PROD_W   = CH_W + RS + 1;
  localparam int PAD_W    = TDATA_W - 2 * PID_W - 2 * SIZE_W;

  // input beat fields
  logic [CODE_W-1:0]  in_code;
  logic [CH_W-1:0]    in_chan;
  logic [LEVEL_W-1:0] in_level;
  logic [CH_W-1:0]    chan_m1;
  logic [PROD_W-1:0]  prod;

  // latched item
  logic [GRP_W-1:0]   item_grp;
  logic               item_valid;
  logic [LEVEL_W-1:0] item_level;
  logic               item_eof;

  // frame and group state
  logic [LEVEL_W-1:0] levels [GROUP_SIZE];
  logic [FILL_W-1:0]  fill_count;
  logic [GRP_W-1:0]   open_group;
  logic               group_open;
  logic [CODE_W-1:0]  frame_code;
  logic               dropping_frame;
  logic               in_frame;
  logic [FILL_W-1:0]  byte_idx;

  logic               reopen;
  logic               room;
  logic [FILL_W-1:0]  idx_m1;
  logic [FILL_W:0]    fill_p1;
  logic [PID_W-1:0]   grp_pid;
  logic [PID_W-1:0]   beat_pid;
  logic [SIZE_W-1:0]  beat_size;
  logic [SIZE_W-1:0]  beat_index;
  logic [LEVEL_W-1:0] beat_value;
  logic               beat_plast;

  assign in_code  = s_tdata[CODE_W-1:0];
  assign in_chan  = s_tdata[CODE_W +: CH_W];
  assign in_level = s_tdata[CODE_W + CH_W +: LEVEL_W];
  assign chan_m1  = in_chan - CH_W'(1);
  assign prod     = PROD_W'(chan_m1) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_grp   <= prod[RS +: GRP_W];
      item_valid <= (in_chan != '0) && (in_chan <= CH_W'(MAX_CHANNEL));
      item_level <= in_level;
      item_eof   <= s_tlast;
    end
  end

  assign reopen = ~group_open | (item_grp != open_group);
  assign room   = fill_count < FILL_W'(GROUP_SIZE);

  always_ff @(posedge clk) begin
    if (cmd.store && (reopen || room)) begin
      levels[reopen ? '0 : fill_count[IDX_W-1:0]] <= item_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      open_group     <= '0;
      group_open     <= 1'b0;
      frame_code     <= '0;
      dropping_frame <= 1'b0;
      in_frame       <= 1'b0;
    end else if (cmd.accept) begin
      if (!in_frame) begin
        in_frame       <= 1'b1;
        frame_code     <= in_code;
        dropping_frame <= (in_chan == '0);
        group_open     <= 1'b0;
        fill_count     <= '0;
      end
    end else if (cmd.store) begin
      open_group <= item_grp;
      group_open <= 1'b1;
      if (reopen)    fill_count <= FILL_W'(1);
      else if (room) fill_count <= fill_count + FILL_W'(1);
    end else if (cmd.close_group) begin
      group_open <= 1'b0;
      fill_count <= '0;
    end else if (cmd.clear_frame) begin
      in_frame       <= 1'b0;
      dropping_frame <= 1'b0;
      group_open     <= 1'b0;
      fill_count     <= '0;
    end
  end

  // byte position inside a group burst
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
    end else if (cmd.emit_group) begin
      if (byte_idx == fill_count) byte_idx <= '0;
      else                        byte_idx <= byte_idx + FILL_W'(1);
    end
  end

  assign idx_m1  = byte_idx - FILL_W'(1);
  assign fill_p1 = {1'b0, fill_count} + (FILL_W + 1)'(1);
  assign grp_pid = group_id_base + PID_W'(open_group);

  always_comb begin
    if (cmd.emit_commit) begin
      beat_pid   = commit_id;
      beat_size  = SIZE_W'(1);
      beat_index = '0;
      beat_value = frame_code;
      beat_plast = 1'b1;
    end else begin
      beat_pid   = grp_pid;
      beat_size  = fill_p1[SIZE_W-1:0];
      beat_index = SIZE_W'(byte_idx);
      beat_value = (byte_idx == '0) ? frame_code : levels[idx_m1[IDX_W-1:0]];
      beat_plast = (byte_idx == fill_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_group || cmd.emit_commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_group || cmd.emit_commit) begin
      m_tdata <= {{PAD_W{1'b0}}, beat_value, beat_index, beat_size, beat_pid};
      m_tlast <= beat_plast;
      m_tuser <= cmd.run_last;
    end
  end

  assign sts.valid_store  = item_valid & ~dropping_frame;
  assign sts.change       = group_open & (item_grp != open_group);
  assign sts.flush_needed = ~dropping_frame &
                            (item_valid | (group_open & (fill_count != '0)));
  assign sts.dropping     = dropping_frame;
  assign sts.eof          = item_eof;
  assign sts.last_byte    = (byte_idx == fill_count);
  assign sts.out_free     = ~m_tvalid | m_tready;

endmodule

// File: design/dmx_channel_group_packetizer.sv
// top level: dmx channel levels in, per-group packets and commit beats out
// an item is latched and processed in the next cycle; no new item until it is done
// a group change adds one output beat per stored level plus the start code
// kept frame end: flush burst if needed, commit beat; a beat a cycle unless stalled
// first output beat: item register, process state, emit state, output register
// synchronous active-high rst: idle, no frame, no group open, registers at defaults
module dmx_channel_group_packetizer #(
  parameter int GROUP_SIZE  = dcgp_pkg::GROUP_SIZE_DEF,
  parameter int MAX_CHANNEL = dcgp_pkg::MAX_CHANNEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // start_code[7:0], channel[17:8], level[25:18], zero pad
  input  logic [dcgp_pkg::TDATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // program_id[7:0], payload_size[12:8], byte_index[17:13], byte_value[25:18]
  output logic [dcgp_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tlast,
  // run_last[0]
  output logic                         m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcgp_pkg::APB_AW-1:0]  paddr,
  input  logic [dcgp_pkg::APB_DW-1:0]  pwdata,
  output logic [dcgp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import dcgp_pkg::*;

  logic [PID_W-1:0] group_id_base;
  logic [PID_W-1:0] commit_id;
  cmd_t             cmd;
  sts_t             sts;

  dcgp_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .group_id_base (group_id_base),
    .commit_id     (commit_id)
  );

  dcgp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dcgp_dp #(
    .GROUP_SIZE  (GROUP_SIZE),
    .MAX_CHANNEL (MAX_CHANNEL)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .group_id_base (group_id_base),
    .commit_id     (commit_id),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// File: design/dcgp_checker.sv
// port-level checks for the packetizer, bound to the top level
module dcgp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // last beat of a run is always the last byte of a packet
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("run end inside a packet");

  // last byte of a packet sits at payload_size - 1
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[17:13] + 5'd1) == m_tdata[12:8])
    else $error("packet end does not match payload size");

  // an accepted item is always processed before the next one is taken
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  // nothing offered right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind dmx_channel_group_packetizer dcgp_checker u_dcgp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// testbench for the dmx channel group packetizer: directed and random frames checked beat by beat
module tb;
  import dcgp_pkg::*;

  localparam int GRP         = 16;
  localparam int MAXCH       = 512;
  localparam int DRAIN_CYC   = 10;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] idx;
    logic [7:0]        val;
    logic              plast;
    logic              rlast;
  } beat_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tlast;
  logic                m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [APB_AW-1:0]   paddr    = '0;
  logic [APB_DW-1:0]   pwdata   = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  dmx_channel_group_packetizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // own copy of the packetizer state
  logic [7:0] id_base    = GROUP_ID_BASE_RST;
  logic [7:0] commit_pid = COMMIT_ID_RST;
  logic [7:0] levels [GRP];
  logic [7:0] code_latch = '0;
  int         fill       = 0;
  int         grp        = 0;
  bit         grp_open   = 0;
  bit         in_frm     = 0;
  bit         dropping   = 0;

  beat_t pending_beats[$];
  beat_t step_beats[$];
  int    mismatches = 0;
  int    sent_levels = 0;
  int    idle_cnt = 0;
  int    stall_left = 0;
  bit    quiet = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void emit_open_group();
    beat_t b;
    b.pid   = id_base + 8'(grp);
    b.size  = 5'(fill + 1);
    b.idx   = '0;
    b.val   = code_latch;
    b.plast = (fill == 0);
    b.rlast = 1'b0;
    step_beats.push_back(b);
    for (int i = 0; i < fill; i++) begin
      b.idx   = 5'(i + 1);
      b.val   = levels[i];
      b.plast = (i + 1 == fill);
      step_beats.push_back(b);
    end
  endfunction

  function automatic void packetize_level(input logic [7:0] code, input logic [9:0] ch,
                                          input logic [7:0] lvl, input logic eof);
    int    g;
    beat_t b;
    step_beats.delete();
    if (!in_frm) begin
      in_frm     = 1;
      code_latch = code;
      dropping   = (ch == 0);
      grp_open   = 0;
      fill       = 0;
    end
    if (!dropping && ch >= 1 && ch <= MAXCH) begin
      g = (int'(ch) - 1) / GRP;
      if (grp_open && g != grp) begin
        emit_open_group();
        fill = 0;
      end
      if (!grp_open || g != grp) begin
        grp      = g;
        grp_open = 1;
        fill     = 0;
      end
      if (fill < GRP) begin
        levels[fill] = lvl;
        fill++;
      end
    end
    if (eof) begin
      if (!dropping) begin
        if (grp_open && fill > 0) emit_open_group();
        b.pid   = commit_pid;
        b.size  = 5'd1;
        b.idx   = 5'd0;
        b.val   = code_latch;
        b.plast = 1'b1;
        b.rlast = 1'b0;
        step_beats.push_back(b);
      end
      in_frm   = 0;
      dropping = 0;
      grp_open = 0;
      fill     = 0;
    end
    foreach (step_beats[i]) begin
      b       = step_beats[i];
      b.rlast = (i == step_beats.size() - 1);
      pending_beats.push_back(b);
    end
  endfunction

  task automatic send_level(input logic [7:0] code, input logic [9:0] ch,
                            input logic [7:0] lvl, input logic eof);
    int n;
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, lvl, ch, code};
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    packetize_level(code, ch, lvl, eof);
    sent_levels++;
  endtask

  // block idle: no beat outstanding and the pipeline drained
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_GROUP_ID_BASE) id_base = value;
    else commit_pid = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_group_change();
    quiet = 0;
    send_level(8'h00, 10'd1,   8'h00, 1'b0);
    send_level(8'h00, 10'd0,   8'h11, 1'b0);
    send_level(8'h00, 10'd16,  8'hff, 1'b0);
    send_level(8'h00, 10'd17,  8'h5a, 1'b0);
    send_level(8'h00, 10'd513, 8'h77, 1'b0);
    send_level(8'h00, 10'd512, 8'ha5, 1'b1);
  endtask

  task automatic test_dropped_frame();
    send_level(8'hff, 10'd0,    8'h12, 1'b0);
    send_level(8'h00, 10'd5,    8'h34, 1'b0);
    send_level(8'h55, 10'd1023, 8'hff, 1'b1);
  endtask

  task automatic test_commit_only();
    send_level(8'hff, 10'd1023, 8'h00, 1'b1);
  endtask

  task automatic test_group_overflow();
    for (int i = 0; i < GRP + 1; i++)
      send_level(8'h9c, 10'd3, 8'(i * 17), i == GRP);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(REG_GROUP_ID_BASE, 8'hff);
    write_reg(REG_COMMIT_ID, 8'h00);
    send_level(8'h3c, 10'd500, 8'h01, 1'b0);
    send_level(8'h3c, 10'd2,   8'h02, 1'b1);
  endtask

  task automatic random_frame();
    logic [7:0] code;
    logic [9:0] ch;
    int         len;
    int         pick;
    bit         drop;
    quiet = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) code = $urandom_range(0, 1) ? 8'hff : 8'h00;
    else code = 8'($urandom);
    drop = ($urandom_range(0, 9) == 0);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 20);
    ch   = ($urandom_range(0, 3) == 0) ? 10'd1 : 10'($urandom_range(1, MAXCH));
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 0 && drop) begin
        send_level(code, 10'd0, 8'($urandom), i == len - 1);
      end else if (pick < 8) begin
        send_level(code, 10'($urandom_range(0, 1023)), 8'($urandom), i == len - 1);
      end else begin
        send_level(code, ch, 8'($urandom), i == len - 1);
        if (pick < 15) ch = ch;
        else if (pick < 20) ch = 10'($urandom_range(1, MAXCH));
        else ch = ch + 10'd1;
      end
    end
  endtask

  task automatic random_phase(input logic [7:0] base, input logic [7:0] cid, input int count);
    int start;
    settle();
    write_reg(REG_GROUP_ID_BASE, base);
    write_reg(REG_COMMIT_ID, cid);
    start = sent_levels;
    while (sent_levels - start < count) random_frame();
    quiet = 0;
  endtask

  task automatic test_random_frames();
    random_phase(8'h00, 8'hff, 100);
    random_phase(8'($urandom), 8'($urandom), 100);
    random_phase(8'hff, 8'h00, 80);
    random_phase(8'($urandom), 8'($urandom), 140);
  endtask

  always @(posedge clk) begin
    if (quiet) begin
      m_tready  <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      stall_left = gap_len();
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.pid   = m_tdata[7:0];
      got.size  = m_tdata[12:8];
      got.idx   = m_tdata[17:13];
      got.val   = m_tdata[25:18];
      got.plast = m_tlast;
      got.rlast = m_tuser;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("program_id", want.pid, got.pid);
        check_field("payload_size", 8'(want.size), 8'(got.size));
        check_field("byte_index", 8'(want.idx), 8'(got.idx));
        check_field("byte_value", want.val, got.val);
        check_field("packet_last", 8'(want.plast), 8'(got.plast));
        check_field("run_last", 8'(want.rlast), 8'(got.rlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_group_change();
    test_dropped_frame();
    test_commit_only();
    test_group_overflow();
    test_register_extremes();
    test_random_frames();
    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/dcgp_pkg.sv
design/dcgp_cfg.sv
design/dcgp_ctrl.sv
design/dcgp_dp.sv
design/dmx_channel_group_packetizer.sv
design/dcgp_checker.sv
verif/tb.sv
